// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the cache RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// when ante holds, cons must hold in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lkv_pkg.sv =====
// Shared sizes, codes and inter-module structs of the LRU key-value cache.
// No dependencies.
`default_nettype none

package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int CMP_BITS   = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    // update operation broadcast to the cells
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_PROMOTE = 2'd1;
    localparam logic [1:0] OP_INSERT  = 2'd2;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic                  look;    // capture key compare
        logic                  upd;     // apply op this cycle
        logic [1:0]            op;
        logic                  is_put;
        logic                  evict;
        logic [IDX_BITS-1:0]   pivot;   // rank of the hit entry
        logic [IDX_BITS-1:0]   victim;  // rank of the least recent entry
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } cmd_t;

    // handed from cell to cell along the row
    typedef struct packed {
        logic                  found;
        logic [IDX_BITS-1:0]   rank;
        logic [VALUE_BITS-1:0] value;
        logic                  take;    // no free slot claimed yet
    } chain_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lkv_cell.sv =====
// One cache entry: key, value, valid and recency rank, plus its link in the row.
// Depends on lkv_pkg.
`default_nettype none

module lkv_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lkv_pkg::cmd_t  cmd,
    input  wire lkv_pkg::chain_t chain_in,
    output lkv_pkg::chain_t     chain_out,
    output logic                match
);

    logic [lkv_pkg::KEY_BITS-1:0]   key_reg;
    logic [lkv_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic                           valid_reg, valid_next;
    logic [lkv_pkg::IDX_BITS-1:0]   rank_reg, rank_next;
    logic                           match_reg;
    logic                           free_here;
    logic                           target;
    logic                           write_key;

    assign match = match_reg;

    assign free_here = chain_in.take & ~valid_reg;
    assign target    = cmd.evict ? (valid_reg && rank_reg == cmd.victim) : free_here;

    always_comb
    begin
        chain_out.found = chain_in.found | match_reg;
        chain_out.rank  = chain_in.rank | (match_reg ? rank_reg : '0);
        chain_out.value = chain_in.value | (match_reg ? value_reg : '0);
        chain_out.take  = chain_in.take & valid_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        value_next = value_reg;
        write_key  = 1'b0;
        if (cmd.upd)
        begin
            case (cmd.op)
                lkv_pkg::OP_PROMOTE:
                begin
                    if (match_reg)
                    begin
                        rank_next = '0;
                        if (cmd.is_put)
                            value_next = cmd.value;
                    end
                    else if (valid_reg && rank_reg < cmd.pivot)
                        rank_next = rank_reg + 1'b1;
                end
                lkv_pkg::OP_INSERT:
                begin
                    if (target)
                    begin
                        valid_next = 1'b1;
                        rank_next  = '0;
                        value_next = cmd.value;
                        write_key  = 1'b1;
                    end
                    else if (valid_reg)
                        rank_next = rank_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (write_key)
            key_reg <= cmd.key;
        if (cmd.look)
            match_reg <= valid_reg && (key_reg == cmd.key);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: control sequencer and the row of entry cells.
// Depends on lkv_pkg, lkv_cell and assert_macros.svh.
//
//   channel   signals                          direction  handshake
//   request   start, action, key, value        in         start & !busy
//   result    result_strobe, hit, read_value   out        strobe, one cycle
//   config    cfg_valid, cfg_data, cfg_ready   in         valid & ready
//
// An item passes capture, a key compare registered in every cell, then the resolve
// along the cell row and the update; busy holds off the next item until the update is done.
// The result strobe comes in the cycle after the update; the receiver cannot stall.
// Reset empties the cache and sets capacity to 16; cfg_ready is always high.
`default_nettype none

module lru_key_value_cache (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           action,
    input  wire logic [lkv_pkg::KEY_BITS-1:0]   key,
    input  wire logic [lkv_pkg::VALUE_BITS-1:0] value,
    output logic                                result_strobe,
    output logic                                hit,
    output logic [lkv_pkg::VALUE_BITS-1:0]      read_value,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lkv_pkg::CAP_BITS-1:0]   cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic                             act_reg;
    logic [lkv_pkg::KEY_BITS-1:0]     key_reg;
    logic [lkv_pkg::VALUE_BITS-1:0]   value_reg;
    logic [lkv_pkg::CAP_BITS-1:0]     capacity_reg;
    logic [lkv_pkg::CNT_BITS-1:0]     count_reg, count_next;
    logic [lkv_pkg::CNT_BITS-1:0]     victim_full;
    logic [lkv_pkg::CMP_BITS-1:0]     cap_ext, eff_cap, count_ext;
    logic                             strobe_reg;
    logic                             hit_reg;
    logic [lkv_pkg::VALUE_BITS-1:0]   read_value_reg;
    logic                             found;
    logic                             evict;
    logic                             accept;

    lkv_pkg::cmd_t                    cmd;
    lkv_pkg::chain_t                  chain [lkv_pkg::ENTRIES+1];
    logic [lkv_pkg::ENTRIES-1:0]      match_vec;

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start & ~busy;
    assign cfg_ready     = 1'b1;
    assign result_strobe = strobe_reg;
    assign hit           = hit_reg;
    assign read_value    = read_value_reg;

    assign chain[0] = '{found: 1'b0, rank: '0, value: '0, take: 1'b1};

    for (genvar i = 0; i < lkv_pkg::ENTRIES; i++)
    begin : g_cell
        lkv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .match     (match_vec[i])
        );
    end

    assign found = chain[lkv_pkg::ENTRIES].found;

    // capacity zero acts as one, above the entry count it saturates
    always_comb
    begin
        cap_ext   = lkv_pkg::CMP_BITS'(capacity_reg);
        count_ext = lkv_pkg::CMP_BITS'(count_reg);
        if (cap_ext == '0)
            eff_cap = lkv_pkg::CMP_BITS'(1);
        else if (cap_ext > lkv_pkg::CMP_BITS'(lkv_pkg::ENTRIES))
            eff_cap = lkv_pkg::CMP_BITS'(lkv_pkg::ENTRIES);
        else
            eff_cap = cap_ext;
    end

    assign evict       = (count_ext >= eff_cap);
    assign victim_full = count_reg - lkv_pkg::CNT_BITS'(1);

    always_comb
    begin
        cmd.look   = (state_reg == S_LOOK);
        cmd.upd    = (state_reg == S_UPD);
        cmd.is_put = (act_reg == lkv_pkg::ACT_PUT);
        cmd.evict  = evict;
        cmd.pivot  = chain[lkv_pkg::ENTRIES].rank;
        cmd.victim = victim_full[lkv_pkg::IDX_BITS-1:0];
        cmd.key    = key_reg;
        cmd.value  = value_reg;
        if (found)
            cmd.op = lkv_pkg::OP_PROMOTE;
        else if (act_reg == lkv_pkg::ACT_PUT)
            cmd.op = lkv_pkg::OP_INSERT;
        else
            cmd.op = lkv_pkg::OP_NONE;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_LOOK;
            end
            S_LOOK:
                state_next = S_UPD;
            S_UPD:
            begin
                state_next = S_IDLE;
                if (cmd.op == lkv_pkg::OP_INSERT && !evict)
                    count_next = count_reg + 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            capacity_reg <= lkv_pkg::CAP_RESET;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= (state_reg == S_UPD);
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            key_reg   <= key;
            value_reg <= value;
        end
        if (state_reg == S_UPD)
        begin
            hit_reg        <= found;
            read_value_reg <= (found && act_reg == lkv_pkg::ACT_GET)
                              ? chain[lkv_pkg::ENTRIES].value : '0;
        end
    end

`include "assert_macros.svh"

    // live keys are unique, so at most one cell can match
    `ASSERT_IMPL(a_one_match, state_reg == S_UPD, $onehot0(match_vec), "several cells matched")
    // an insert below capacity always finds a free cell
    `ASSERT_IMPL(a_free_slot, cmd.upd && cmd.op == lkv_pkg::OP_INSERT && !evict,
        !chain[lkv_pkg::ENTRIES].take, "insert without a free cell")
    `ASSERT_ALWAYS(a_count_max, count_reg <= lkv_pkg::CNT_BITS'(lkv_pkg::ENTRIES),
        "entry count above table size")
    `ASSERT_IMPL(a_strobe_src, strobe_reg, $past(state_reg) == S_UPD, "stray result strobe")

endmodule

`default_nettype wire
